@@ hdl/brainfuck_execution_core_assert.svh @@
// Assertion macros for the execution core
`ifndef BRAINFUCK_EXECUTION_CORE_ASSERT_SVH
`define BRAINFUCK_EXECUTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define BFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfc assertion failed");
// Next-cycle implication
`define BFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfc assertion failed");
`else
`define BFC_ASSERT_IMP(lbl, ante, cons)
`define BFC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/bfc_pkg.sv @@
package bfc_pkg;

  localparam int TAPE_DEPTH  = 32768;
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_WIDTH  = 16;

  localparam int PTR_W  = $clog2(TAPE_DEPTH);
  localparam int SIDX_W = $clog2(STACK_DEPTH);
  localparam int SCNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SKIP_W = 16;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [SIDX_W-1:0]     sidx_t;
  typedef logic [SCNT_W-1:0]     scnt_t;
  typedef logic [SKIP_W-1:0]     skip_t;
  typedef logic [ADDR_WIDTH-1:0] addr_t;

  localparam skip_t SKIP_MAX = '1;

  // Command characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INC,
    OP_DEC,
    OP_IN,
    OP_OUT,
    OP_RIGHT,
    OP_LEFT,
    OP_OPEN,
    OP_CLOSE
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    RS_CLEAR,
    RS_RUN
  } run_state_t;

  typedef struct packed {
    op_t        op;
    addr_t      addr;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        jump;
    logic [15:0] jump_address;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic ready;
    logic clearing;
  } back_ctl_t;

  // Keep the low ADDR_WIDTH bits of a fetch address
  function automatic addr_t addr_in(input logic [15:0] a);
    logic [47:0] t;
    t = 48'(a);
    return t[ADDR_WIDTH-1:0];
  endfunction

  // Low 16 bits of a stored address
  function automatic logic [15:0] addr_out(input addr_t a);
    logic [47:0] t;
    t = 48'(a);
    return t[15:0];
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(TAPE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_W'(TAPE_DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

endpackage

@@ hdl/bfc_front.sv @@
module bfc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         cmd,
  input  logic [15:0]        after_address,
  input  logic [7:0]         in_byte,
  input  bfc_pkg::back_ctl_t back_ctl,
  output bfc_pkg::item_t     head,
  output logic               head_valid
);

  bfc_pkg::item_t q_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           wr_en, rd_en;
  bfc_pkg::item_t item_new;

  // Decode the character into an operation
  function automatic bfc_pkg::op_t classify(input logic [7:0] c);
    bfc_pkg::op_t op;
    case (c)
      bfc_pkg::CH_PLUS:  op = bfc_pkg::OP_INC;
      bfc_pkg::CH_MINUS: op = bfc_pkg::OP_DEC;
      bfc_pkg::CH_COMMA: op = bfc_pkg::OP_IN;
      bfc_pkg::CH_DOT:   op = bfc_pkg::OP_OUT;
      bfc_pkg::CH_RIGHT: op = bfc_pkg::OP_RIGHT;
      bfc_pkg::CH_LEFT:  op = bfc_pkg::OP_LEFT;
      bfc_pkg::CH_OPEN:  op = bfc_pkg::OP_OPEN;
      bfc_pkg::CH_CLOSE: op = bfc_pkg::OP_CLOSE;
      default:           op = bfc_pkg::OP_NOP;
    endcase
    return op;
  endfunction

  // Hold off the feeder while the queue is full or the tape is clearing
  assign full       = (cnt_r == 2'd2) || back_ctl.clearing;
  assign wr_en      = push && !full;
  assign head_valid = (cnt_r != 2'd0);
  assign rd_en      = head_valid && back_ctl.ready;
  assign head       = q_r[rptr_r];

  always_comb begin
    item_new.op      = classify(cmd);
    item_new.addr    = bfc_pkg::addr_in(after_address);
    item_new.in_byte = in_byte;
  end

  // Advance queue pointers
  always_comb begin
    wptr_nxt = wr_en ? !wptr_r : wptr_r;
    rptr_nxt = rd_en ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the classified transaction
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wptr_r] <= item_new;
    end
  end

endmodule

@@ hdl/bfc_back.sv @@
module bfc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bfc_pkg::item_t     head,
  input  logic               head_valid,
  input  logic               res_ready,
  output bfc_pkg::back_ctl_t back_ctl,
  output bfc_pkg::result_t   res,
  output logic               res_push
);

  // Tape memory and its ports
  logic [7:0]    tape_mem [bfc_pkg::TAPE_DEPTH];
  logic          t_we, t_re;
  bfc_pkg::ptr_t t_wa, t_ra;
  logic [7:0]    t_wd;
  logic [7:0]    t_q;

  // Loop stack memory and its ports
  bfc_pkg::addr_t stack_mem [bfc_pkg::STACK_DEPTH];
  logic           s_we, s_re;
  bfc_pkg::sidx_t s_wa, s_ra;
  bfc_pkg::addr_t s_wd;
  bfc_pkg::addr_t s_q;

  bfc_pkg::run_state_t state_r, state_nxt;
  bfc_pkg::ptr_t       clr_r, clr_nxt;
  logic                clearing, running;

  // Window of cells around the pointer: left, current, right
  bfc_pkg::ptr_t  ptr_r, ptr_nxt;
  logic [7:0]     cl_r, cl_nxt;
  logic [7:0]     cc_r, cc_nxt;
  logic [7:0]     cr_r, cr_nxt;
  logic           pend_l_r, pend_l_nxt;
  logic           pend_r_r, pend_r_nxt;
  logic [7:0]     cl_eff, cr_eff;

  bfc_pkg::scnt_t scnt_r, scnt_nxt;
  bfc_pkg::scnt_t scnt_m1, scnt_m2;
  bfc_pkg::addr_t tos_r, tos_nxt, tos_eff;
  logic           pend_t_r, pend_t_nxt;
  bfc_pkg::skip_t skip_r, skip_nxt;

  logic fire;

  // Next state: sweep the tape once after reset
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfc_pkg::RS_CLEAR: begin
        if (clr_r == bfc_pkg::PTR_W'(bfc_pkg::TAPE_DEPTH - 1)) begin
          state_nxt = bfc_pkg::RS_RUN;
        end
      end
      bfc_pkg::RS_RUN: state_nxt = bfc_pkg::RS_RUN;
      default:         state_nxt = bfc_pkg::RS_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    clearing = 1'b0;
    running  = 1'b0;
    case (state_r)
      bfc_pkg::RS_CLEAR: clearing = 1'b1;
      bfc_pkg::RS_RUN:   running  = 1'b1;
      default:           clearing = 1'b1;
    endcase
  end

  assign back_ctl.ready    = running && res_ready;
  assign back_ctl.clearing = clearing;
  assign fire              = head_valid && running && res_ready;
  assign res_push          = fire;

  assign cl_eff  = pend_l_r ? t_q : cl_r;
  assign cr_eff  = pend_r_r ? t_q : cr_r;
  assign tos_eff = pend_t_r ? s_q : tos_r;
  assign scnt_m1 = scnt_r - bfc_pkg::SCNT_W'(1);
  assign scnt_m2 = scnt_r - bfc_pkg::SCNT_W'(2);

  // Execute one transaction
  always_comb begin
    clr_nxt    = clearing ? bfc_pkg::ptr_t'(clr_r + 1'b1) : clr_r;
    ptr_nxt    = ptr_r;
    cl_nxt     = cl_eff;
    cc_nxt     = cc_r;
    cr_nxt     = cr_eff;
    pend_l_nxt = 1'b0;
    pend_r_nxt = 1'b0;
    scnt_nxt   = scnt_r;
    tos_nxt    = tos_eff;
    pend_t_nxt = 1'b0;
    skip_nxt   = skip_r;

    t_we = clearing;
    t_wa = clr_r;
    t_wd = 8'd0;
    t_re = 1'b0;
    t_ra = ptr_r;
    s_we = 1'b0;
    s_wa = scnt_m1[bfc_pkg::SIDX_W-1:0];
    s_wd = tos_eff;
    s_re = 1'b0;
    s_ra = scnt_m2[bfc_pkg::SIDX_W-1:0];

    res.out_valid    = 1'b0;
    res.out_byte     = 8'd0;
    res.jump         = 1'b0;
    res.jump_address = 16'd0;
    res.status       = bfc_pkg::STAT_OK;

    if (fire) begin
      if (skip_r != '0) begin
        // Skip mode: track bracket nesting only
        if (head.op == bfc_pkg::OP_OPEN) begin
          if (skip_r != bfc_pkg::SKIP_MAX) begin
            skip_nxt = skip_r + 1'b1;
          end
        end else if (head.op == bfc_pkg::OP_CLOSE) begin
          skip_nxt = skip_r - 1'b1;
        end
      end else begin
        case (head.op)
          bfc_pkg::OP_INC: cc_nxt = cc_r + 8'd1;
          bfc_pkg::OP_DEC: cc_nxt = cc_r - 8'd1;
          bfc_pkg::OP_IN:  cc_nxt = head.in_byte;
          bfc_pkg::OP_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte  = cc_r;
          end
          bfc_pkg::OP_RIGHT: begin
            // Retire the left cell, slide the window, fetch the new right cell
            t_we       = 1'b1;
            t_wa       = bfc_pkg::ptr_dec(ptr_r);
            t_wd       = cl_eff;
            t_re       = 1'b1;
            t_ra       = bfc_pkg::ptr_inc(bfc_pkg::ptr_inc(ptr_r));
            ptr_nxt    = bfc_pkg::ptr_inc(ptr_r);
            cl_nxt     = cc_r;
            cc_nxt     = cr_eff;
            pend_r_nxt = 1'b1;
          end
          bfc_pkg::OP_LEFT: begin
            t_we       = 1'b1;
            t_wa       = bfc_pkg::ptr_inc(ptr_r);
            t_wd       = cr_eff;
            t_re       = 1'b1;
            t_ra       = bfc_pkg::ptr_dec(bfc_pkg::ptr_dec(ptr_r));
            ptr_nxt    = bfc_pkg::ptr_dec(ptr_r);
            cr_nxt     = cc_r;
            cc_nxt     = cl_eff;
            pend_l_nxt = 1'b1;
          end
          bfc_pkg::OP_OPEN: begin
            if (cc_r == 8'd0) begin
              skip_nxt = bfc_pkg::skip_t'(1);
            end else if (scnt_r == bfc_pkg::SCNT_W'(bfc_pkg::STACK_DEPTH)) begin
              res.status = bfc_pkg::STAT_OVERFLOW;
            end else begin
              // Spill the old top into memory, keep the new one in a register
              s_we     = (scnt_r != '0);
              tos_nxt  = head.addr;
              scnt_nxt = scnt_r + 1'b1;
            end
          end
          bfc_pkg::OP_CLOSE: begin
            if (scnt_r == '0) begin
              res.status = bfc_pkg::STAT_UNDERFLOW;
            end else if (cc_r == 8'd0) begin
              // Pop and fetch the entry below the top
              scnt_nxt   = scnt_m1;
              s_re       = (scnt_r != bfc_pkg::SCNT_W'(1));
              pend_t_nxt = (scnt_r != bfc_pkg::SCNT_W'(1));
            end else begin
              res.jump         = 1'b1;
              res.jump_address = bfc_pkg::addr_out(tos_eff);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bfc_pkg::RS_CLEAR;
      clr_r    <= '0;
      ptr_r    <= '0;
      cl_r     <= 8'd0;
      cc_r     <= 8'd0;
      cr_r     <= 8'd0;
      pend_l_r <= 1'b0;
      pend_r_r <= 1'b0;
      scnt_r   <= '0;
      pend_t_r <= 1'b0;
      skip_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ptr_r    <= ptr_nxt;
      cl_r     <= cl_nxt;
      cc_r     <= cc_nxt;
      cr_r     <= cr_nxt;
      pend_l_r <= pend_l_nxt;
      pend_r_r <= pend_r_nxt;
      scnt_r   <= scnt_nxt;
      pend_t_r <= pend_t_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // Top of stack holds no reset
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
  end

  // Tape memory
  always_ff @(posedge clk) begin
    if (t_we) begin
      tape_mem[t_wa] <= t_wd;
    end
    if (t_re) begin
      t_q <= tape_mem[t_ra];
    end
  end

  // Loop stack memory
  always_ff @(posedge clk) begin
    if (s_we) begin
      stack_mem[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_q <= stack_mem[s_ra];
    end
  end

endmodule

@@ hdl/bfc_outq.sv @@
module bfc_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_push,
  input  bfc_pkg::result_t res,
  output logic             res_ready,
  input  logic             pop,
  output logic             empty,
  output bfc_pkg::result_t head
);

  bfc_pkg::result_t q_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             rd_en;

  assign empty     = (cnt_r == 2'd0);
  assign rd_en     = pop && !empty;
  assign res_ready = (cnt_r != 2'd2) || pop;
  assign head      = q_r[rptr_r];

  // Advance queue pointers
  always_comb begin
    wptr_nxt = res_push ? !wptr_r : wptr_r;
    rptr_nxt = rd_en ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (res_push && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !res_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold results until popped
  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wptr_r] <= res;
    end
  end

endmodule

@@ hdl/brainfuck_execution_core.sv @@
// Path: an accepted transaction passes the front queue and back end into the result queue.
// Throughput: one transaction per cycle while the result queue can take it; the tape window
// and top-of-stack register forward values so no command waits for a memory read.
// Reset: pointer, stack count and skip depth clear at once; the tape is then swept
// to zero cell by cell, with full held high until the sweep ends.
`include "brainfuck_execution_core_assert.svh"

module brainfuck_execution_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_cmd,
  input  logic [15:0] in_after_address,
  input  logic [7:0]  in_in_byte,
  output logic        empty,
  input  logic        pop,
  output logic        out_out_valid,
  output logic [7:0]  out_out_byte,
  output logic        out_jump,
  output logic [15:0] out_jump_address,
  output logic [1:0]  out_status
);

  bfc_pkg::back_ctl_t back_ctl;
  bfc_pkg::item_t     head;
  logic               head_valid;
  bfc_pkg::result_t   res;
  logic               res_push;
  logic               res_ready;
  bfc_pkg::result_t   res_head;

  // Accept and classify
  bfc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .cmd           (in_cmd),
    .after_address (in_after_address),
    .in_byte       (in_in_byte),
    .back_ctl      (back_ctl),
    .head          (head),
    .head_valid    (head_valid)
  );

  // Execute against tape and loop stack
  bfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .res_ready  (res_ready),
    .back_ctl   (back_ctl),
    .res        (res),
    .res_push   (res_push)
  );

  // Queue results
  bfc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready),
    .pop       (pop),
    .empty     (empty),
    .head      (res_head)
  );

  assign out_out_valid    = res_head.out_valid;
  assign out_out_byte     = res_head.out_byte;
  assign out_jump         = res_head.jump;
  assign out_jump_address = res_head.jump_address;
  assign out_status       = res_head.status;

  `BFC_ASSERT_IMP(a_full_while_clearing, back_ctl.clearing, full)
  `BFC_ASSERT_NXT(a_result_lands, res_push, !empty)
  `BFC_ASSERT_IMP(a_jump_alone, !empty && out_jump, out_status == bfc_pkg::STAT_OK && !out_out_valid)

endmodule
